// ===== design/kms_pkg.sv =====
// ----------------------------------------------------------------------------
// kms_pkg: shared types and constants of the keypad matrix scanner
// Scan phases, register indexes, reset values and the structs passed between
// the configuration registers, the scan core and the top level.
// ----------------------------------------------------------------------------
package kms_pkg;

	// matrix geometry defaults
	localparam int LINE_COUNT_DEF   = 5;
	localparam int COLUMN_COUNT_DEF = 3;

	// fixed field widths
	localparam int SENSE_W  = 5;
	localparam int DRIVE_W  = 3;
	localparam int INDEX_W  = 4;
	localparam int CHAR_W   = 8;
	localparam int MAP_W    = 15;
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 2;

	// register reset values
	localparam logic [CFG_W-1:0] PRESS_WINDOW_RST   = 8'd20;
	localparam logic [CFG_W-1:0] RELEASE_WINDOW_RST = 8'd5;
	localparam logic [CFG_W-1:0] SETTLE_RST         = 8'd5;
	localparam logic [CFG_W-1:0] PAUSE_RST          = 8'd5;

	// key characters run from 'A' upward in key order
	localparam logic [CHAR_W-1:0] KEY_CHAR_BASE = 8'h41;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PRESS_WINDOW   = 2'd0,
		REG_RELEASE_WINDOW = 2'd1,
		REG_SETTLE         = 2'd2,
		REG_SCAN_PAUSE     = 2'd3
	} kms_reg_e;

	// scan phases
	typedef enum logic [2:0] {
		PH_SETTLE  = 3'd0,
		PH_JUDGE   = 3'd1,
		PH_PRESS   = 3'd2,
		PH_RELEASE = 3'd3,
		PH_PAUSE   = 3'd4
	} kms_phase_e;

	// configuration seen by the scan core
	typedef struct packed {
		logic [CFG_W-1:0] press_window_ms;
		logic [CFG_W-1:0] release_window_ms;
		logic [CFG_W-1:0] settle_samples;
		logic [CFG_W-1:0] scan_pause_ms;
	} kms_cfg_t;

	// one result item
	typedef struct packed {
		logic [DRIVE_W-1:0] column_drive;
		logic               key_valid;
		logic [INDEX_W-1:0] key_index;
		logic [CHAR_W-1:0]  key_char;
		logic [MAP_W-1:0]   pressed_map;
	} kms_result_t;

endpackage

// ===== design/kms_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// kms_cfg_regs: configuration registers
// Holds the two debounce windows, the settle count and the scan pause.
// ----------------------------------------------------------------------------
module kms_cfg_regs
	import kms_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output kms_cfg_t             cfg
);

	kms_cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register write on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_window_ms   <= PRESS_WINDOW_RST;
			cfg_q.release_window_ms <= RELEASE_WINDOW_RST;
			cfg_q.settle_samples    <= SETTLE_RST;
			cfg_q.scan_pause_ms     <= PAUSE_RST;
		end else if (cfg_valid) begin
			unique case (kms_reg_e'(cfg_index))
				REG_PRESS_WINDOW:   cfg_q.press_window_ms   <= cfg_data;
				REG_RELEASE_WINDOW: cfg_q.release_window_ms <= cfg_data;
				REG_SETTLE:         cfg_q.settle_samples    <= cfg_data;
				REG_SCAN_PAUSE:     cfg_q.scan_pause_ms     <= cfg_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/kms_scan_core.sv =====
// ----------------------------------------------------------------------------
// kms_scan_core: scan sequencer and debounce judge
// Holds the scan position, phase, window counter and stable key map, and
// works out one result from one sample combinationally.
// ----------------------------------------------------------------------------
module kms_scan_core
	import kms_pkg::*;
#(
	parameter int LINE_COUNT   = LINE_COUNT_DEF,
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [SENSE_W-1:0] sense,
	input  logic               tick,
	input  kms_cfg_t           cfg,
	output kms_result_t        result
);

	localparam int KEYS = LINE_COUNT * COLUMN_COUNT;
	localparam int LW   = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
	localparam int CW   = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
	localparam int KW   = (KEYS > 1) ? $clog2(KEYS) : 1;

	kms_phase_e       phase_q, phase_d;
	logic [CW-1:0]    col_q, col_d;
	logic [LW-1:0]    line_q, line_d;
	logic [CFG_W-1:0] ctr_q, ctr_d;
	logic [KEYS-1:0]  stable_q, stable_d;

	logic [7:0]       sense_ext;
	logic             low;
	logic [CFG_W-1:0] ctr_inc;
	logic [KW-1:0]    key_k;
	logic             judge;
	logic             dec;
	logic             dec_val;
	logic [LW:0]      line_nx;
	logic [CW:0]      col_nx;
	logic [7:0]       col_onehot;
	logic [KEYS+MAP_W-1:0] map_ext;
	logic             emit;

	// sense line of the current key, lines past the field read high
	assign sense_ext = {{(8 - SENSE_W){1'b1}}, sense};
	assign low       = !sense_ext[3'(line_q)];

	// saturating millisecond count
	assign ctr_inc = (tick && ctr_q != 8'hFF) ? ctr_q + 8'd1 : ctr_q;

	// key number of the current position
	assign key_k = KW'(KW'(col_q) * KW'(LINE_COUNT)) + KW'(line_q);

	assign line_nx = {1'b0, line_q} + (LW+1)'(1);
	assign col_nx  = {1'b0, col_q} + (CW+1)'(1);

	// next state
	always_comb begin
		phase_d  = phase_q;
		ctr_d    = ctr_q;
		col_d    = col_q;
		line_d   = line_q;
		stable_d = stable_q;
		judge    = 1'b0;
		dec      = 1'b0;
		dec_val  = 1'b0;

		unique case (phase_q)
			PH_PAUSE: begin
				if (ctr_inc >= cfg.scan_pause_ms) begin
					phase_d = PH_SETTLE;
					ctr_d   = '0;
					col_d   = '0;
					line_d  = '0;
				end else begin
					ctr_d = ctr_inc;
				end
			end
			PH_JUDGE: begin
				judge = 1'b1;
			end
			PH_PRESS: begin
				if (ctr_inc >= cfg.press_window_ms) begin
					dec     = 1'b1;
					dec_val = 1'b1;
				end else if (!low) begin
					dec = 1'b1;
				end else begin
					ctr_d = ctr_inc;
				end
			end
			PH_RELEASE: begin
				if (ctr_inc >= cfg.release_window_ms) begin
					dec = 1'b1;
				end else if (low) begin
					dec     = 1'b1;
					dec_val = 1'b1;
				end else begin
					ctr_d = ctr_inc;
				end
			end
			default: begin
				phase_d = PH_SETTLE;
				if (ctr_q < cfg.settle_samples) begin
					ctr_d = ctr_q + 8'd1;
				end else begin
					judge = 1'b1;
				end
			end
		endcase

		// first sample of a key: zero windows decide at once
		if (judge) begin
			ctr_d = '0;
			if (low) begin
				if (cfg.press_window_ms == '0) begin
					dec     = 1'b1;
					dec_val = 1'b1;
				end else begin
					phase_d = PH_PRESS;
				end
			end else if (cfg.release_window_ms == '0) begin
				dec = 1'b1;
			end else begin
				phase_d = PH_RELEASE;
			end
		end

		// key decided: store it and move to the next position
		if (dec) begin
			stable_d[key_k] = dec_val;
			ctr_d = '0;
			if (line_nx >= (LW+1)'(LINE_COUNT)) begin
				line_d = '0;
				if (col_nx >= (CW+1)'(COLUMN_COUNT)) begin
					col_d   = '0;
					phase_d = PH_PAUSE;
				end else begin
					col_d   = col_nx[CW-1:0];
					phase_d = PH_SETTLE;
				end
			end else begin
				line_d  = line_nx[LW-1:0];
				phase_d = PH_JUDGE;
			end
		end
	end

	// result outputs
	assign col_onehot = 8'(1) << 3'(col_q);
	assign map_ext    = {{MAP_W{1'b0}}, stable_d};
	assign emit       = dec && dec_val && !stable_q[key_k];

	always_comb begin
		result.column_drive = (phase_q == PH_PAUSE) ? '0 : col_onehot[DRIVE_W-1:0];
		result.key_valid    = emit;
		result.key_index    = emit ? INDEX_W'(key_k) : '0;
		result.key_char     = emit ? KEY_CHAR_BASE + CHAR_W'(key_k) : '0;
		result.pressed_map  = map_ext[MAP_W-1:0];
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SETTLE;
			col_q    <= '0;
			line_q   <= '0;
			ctr_q    <= '0;
			stable_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			col_q    <= col_d;
			line_q   <= line_d;
			ctr_q    <= ctr_d;
			stable_q <= stable_d;
		end
	end

`ifndef NO_ASSERTIONS
	// the pause always sits at the start position
	a_pause_home: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAUSE |-> col_q == '0 && line_q == '0)
		else $error("pause phase away from the start position");

	// no sample, no change of scan state
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(stable_q) && $stable(ctr_q))
		else $error("scan state moved without a sample");

	// a reported key adds exactly one key to the map
	a_emit_adds: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.key_valid |=>
			$countones(stable_q) == $past($countones(stable_q)) + 1)
		else $error("reported key did not enter the key map");

	// watch phases only on a real line
	a_line_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PRESS || phase_q == PH_RELEASE) |->
			{1'b0, line_q} < (LW+1)'(LINE_COUNT))
		else $error("watch phase on a line outside the matrix");
`endif

endmodule

// ===== design/keypad_matrix_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// keypad_matrix_scanner_unit: debounced key matrix scanner
// Drives one column at a time, debounces each key against millisecond
// windows and reports newly pressed keys with their index and character.
//
//   channel | dir | handshake           | payload
//   s_*     | in  | s_tvalid / s_tready | s_tdata: sense_levels, ms_tick
//   m_*     | out | m_tvalid / m_tready | m_tdata: drive, index, char, map;
//           |     |                     | m_tuser: key_valid
//   cfg_*   | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One sample is taken per cycle while the result stream is not stalled, and gives one
// result; it passes the input register and the result register around the scan core.
// Reset loads the register defaults and starts the scan in the settle phase.
// A stalled result holds the core; the input register takes one more sample if it is
// empty, then s_tready falls until the result is taken.
// ----------------------------------------------------------------------------
module keypad_matrix_scanner_unit
	import kms_pkg::*;
#(
	parameter int LINE_COUNT   = LINE_COUNT_DEF,
	parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// sample stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,  // [4:0] sense_levels, [5] ms_tick, [7:6] zero
	// result stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,  // [2:0] column_drive, [6:3] key_index,
	                                       // [14:7] key_char, [29:15] pressed_map,
	                                       // [31:30] zero
	output logic                 m_tuser,  // [0] key_valid
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	kms_cfg_t     cfg;
	kms_result_t  result;
	kms_result_t  res_q;

	logic               in_valid_s1;
	logic [SENSE_W-1:0] sense_s1;
	logic               tick_s1;
	logic               out_valid_q;
	logic               adv;

	// configuration registers
	kms_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// pipeline advance when the input register holds a sample and the result register is free or being taken
	assign adv      = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sense_s1 <= s_tdata[SENSE_W-1:0];
			tick_s1  <= s_tdata[SENSE_W];
		end
	end

	// scan core
	kms_scan_core #(
		.LINE_COUNT   (LINE_COUNT),
		.COLUMN_COUNT (COLUMN_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.sense  (sense_s1),
		.tick   (tick_s1),
		.cfg    (cfg),
		.result (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= result;
		end
	end

	// result transfer
	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.key_valid;
	assign m_tdata  = {2'b00, res_q.pressed_map, res_q.key_char,
		res_q.key_index, res_q.column_drive};

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the keypad matrix scanner unit
// Streams sense samples with millisecond ticks into the scanner and checks
// every result against a cycle-free scan predictor kept in the bench. Runs
// through several window, settle and pause settings, each written while the
// scanner is drained, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
	import kms_pkg::*;

	localparam int BATCHES     = 15;
	localparam int BATCH_LEN   = 110;
	localparam int DRAIN_WAIT  = 4;
	localparam int LONG_HOLD   = 150;
	localparam int TAIL_CYCLES = 10;

	typedef enum {STEP_SAMPLE, STEP_WRITE, STEP_DRAIN, STEP_HOLD} step_kind_e;

	typedef struct {
		step_kind_e       kind;
		logic [4:0]       sense;
		logic             tick;
		kms_reg_e         reg_idx;
		logic [CFG_W-1:0] value;
	} scan_step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [31:0]          m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	keypad_matrix_scanner_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// stimulus plan and expected results
	scan_step_t  scan_plan[$];
	kms_result_t expected_results[$];

	// scan predictor state and settings
	logic [CFG_W-1:0] press_win, release_win, settle_len, pause_len;
	logic [1:0]       scan_col;
	logic [2:0]       scan_line;
	kms_phase_e       scan_ph;
	logic [7:0]       ms_count;
	logic [MAP_W-1:0] held_keys;
	logic             new_key;
	logic [INDEX_W-1:0] new_key_idx;

	// bookkeeping
	int check_errors = 0;
	int planned_samples = 0;
	int writes_done = 0;
	int keys_reported = 0;
	int holds_done = 0;

	// handshake flags, sampled at the rising edge
	logic s_done = 1'b0;
	logic cfg_done = 1'b0;
	logic sample_busy = 1'b0;
	logic write_busy = 1'b0;
	int   hold_requests = 0;

	initial begin
		press_win   = PRESS_WINDOW_RST;
		release_win = RELEASE_WINDOW_RST;
		settle_len  = SETTLE_RST;
		pause_len   = PAUSE_RST;
		scan_col    = '0;
		scan_line   = '0;
		scan_ph     = PH_SETTLE;
		ms_count    = '0;
		held_keys   = '0;
	end

	// ------------------------------------------------------------------
	// scan predictor
	// ------------------------------------------------------------------
	function automatic void bump_ms(logic tick);
		if (tick && ms_count != 8'hff)
			ms_count++;
	endfunction

	// settle the current key and move on to the next line, column or pause
	function automatic void close_key(logic pressed);
		logic [INDEX_W-1:0] k;
		k = INDEX_W'(scan_col * LINE_COUNT_DEF + scan_line);
		if (pressed && !held_keys[k]) begin
			new_key = 1'b1;
			new_key_idx = k;
		end
		held_keys[k] = pressed;
		ms_count = '0;
		if (scan_line == 3'(LINE_COUNT_DEF - 1)) begin
			scan_line = '0;
			if (scan_col == 2'(COLUMN_COUNT_DEF - 1)) begin
				scan_col = '0;
				scan_ph = PH_PAUSE;
			end else begin
				scan_col++;
				scan_ph = PH_SETTLE;
			end
		end else begin
			scan_line++;
			scan_ph = PH_JUDGE;
		end
	endfunction

	// first sample of a key picks the watch window
	function automatic void first_look(logic [4:0] sense);
		ms_count = '0;
		if (!sense[scan_line]) begin
			if (press_win == '0)
				close_key(1'b1);
			else
				scan_ph = PH_PRESS;
		end else begin
			if (release_win == '0)
				close_key(1'b0);
			else
				scan_ph = PH_RELEASE;
		end
	endfunction

	function automatic kms_result_t scan_sample(logic [4:0] sense, logic tick);
		kms_result_t r;
		r = '0;
		new_key = 1'b0;
		new_key_idx = '0;
		if (scan_ph != PH_PAUSE)
			r.column_drive = DRIVE_W'(1) << scan_col;
		case (scan_ph)
			PH_PAUSE: begin
				bump_ms(tick);
				if (ms_count >= pause_len) begin
					scan_ph = PH_SETTLE;
					ms_count = '0;
					scan_col = '0;
					scan_line = '0;
				end
			end
			PH_JUDGE: first_look(sense);
			PH_PRESS: begin
				// tick counts first, then the window or the level decides
				bump_ms(tick);
				if (ms_count >= press_win)
					close_key(1'b1);
				else if (sense[scan_line])
					close_key(1'b0);
			end
			PH_RELEASE: begin
				bump_ms(tick);
				if (ms_count >= release_win)
					close_key(1'b0);
				else if (!sense[scan_line])
					close_key(1'b1);
			end
			default: begin
				// settle phase, counted in samples
				scan_ph = PH_SETTLE;
				if (ms_count < settle_len)
					ms_count++;
				else
					first_look(sense);
			end
		endcase
		r.key_valid = new_key;
		if (new_key) begin
			r.key_index = new_key_idx;
			r.key_char = KEY_CHAR_BASE + CHAR_W'(new_key_idx);
		end
		r.pressed_map = held_keys;
		return r;
	endfunction

	function automatic void apply_write(kms_reg_e idx, logic [CFG_W-1:0] v);
		case (idx)
			REG_PRESS_WINDOW:   press_win = v;
			REG_RELEASE_WINDOW: release_win = v;
			REG_SETTLE:         settle_len = v;
			REG_SCAN_PAUSE:     pause_len = v;
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			check_errors++;
		end
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// ------------------------------------------------------------------
	// plan building
	// ------------------------------------------------------------------
	task automatic add_sample(logic [4:0] sense, logic tick);
		scan_step_t st;
		st = '{STEP_SAMPLE, sense, tick, REG_PRESS_WINDOW, '0};
		scan_plan.push_back(st);
		planned_samples++;
	endtask

	// drain the scanner, then write all four registers
	task automatic add_settings(logic [7:0] press, logic [7:0] rel, logic [7:0] settle,
			logic [7:0] pause);
		scan_plan.push_back('{STEP_DRAIN, 5'h1f, 1'b0, REG_PRESS_WINDOW, '0});
		scan_plan.push_back('{STEP_WRITE, 5'h1f, 1'b0, REG_PRESS_WINDOW, press});
		scan_plan.push_back('{STEP_WRITE, 5'h1f, 1'b0, REG_RELEASE_WINDOW, rel});
		scan_plan.push_back('{STEP_WRITE, 5'h1f, 1'b0, REG_SETTLE, settle});
		scan_plan.push_back('{STEP_WRITE, 5'h1f, 1'b0, REG_SCAN_PAUSE, pause});
	endtask

	function automatic logic [7:0] pick_setting();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 8'd0;
		if (r == 1)
			return 8'd255;
		return 8'($urandom_range(1, 10));
	endfunction

	// ------------------------------------------------------------------
	// rising edge: transfers, prediction and checking
	// ------------------------------------------------------------------
	always @(posedge clk) begin : monitor
		kms_result_t want;
		s_done = s_tvalid && s_tready;
		cfg_done = cfg_valid && cfg_ready;
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no sample waiting");
				check_errors++;
			end else begin
				want = expected_results.pop_front();
				check_field("column_drive", 32'(want.column_drive), 32'(m_tdata[2:0]));
				check_field("key_valid", 32'(want.key_valid), 32'(m_tuser));
				check_field("key_index", 32'(want.key_index), 32'(m_tdata[6:3]));
				check_field("key_char", 32'(want.key_char), 32'(m_tdata[14:7]));
				check_field("pressed_map", 32'(want.pressed_map), 32'(m_tdata[29:15]));
				if (m_tuser)
					keys_reported++;
			end
		end
		if (cfg_done) begin
			apply_write(kms_reg_e'(cfg_index), cfg_data);
			writes_done++;
		end
		if (s_done)
			expected_results.push_back(scan_sample(s_tdata[4:0], s_tdata[5]));
	end

	// ------------------------------------------------------------------
	// sender: samples and register writes from the plan
	// ------------------------------------------------------------------
	int unsigned send_gap = 0;
	int unsigned drain_left = DRAIN_WAIT;
	logic        send_calm = 1'b0;
	logic [7:0]  next_tdata = '0;
	logic [CFG_IDX_W-1:0] next_index = '0;
	logic [CFG_W-1:0]     next_data = '0;

	always @(negedge clk) begin : sender
		scan_step_t head;
		if (arst_n) begin
			if (s_done)
				sample_busy = 1'b0;
			if (cfg_done)
				write_busy = 1'b0;
			if (!sample_busy && !write_busy) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (scan_plan.size() > 0) begin
					head = scan_plan[0];
					case (head.kind)
						STEP_SAMPLE: begin
							void'(scan_plan.pop_front());
							sample_busy = 1'b1;
							next_tdata = {2'b00, head.tick, head.sense};
							if ($urandom_range(0, 49) == 0)
								send_calm = !send_calm;
							send_gap = send_calm ? 0 : draw_gap();
						end
						STEP_WRITE: begin
							void'(scan_plan.pop_front());
							write_busy = 1'b1;
							next_index = head.reg_idx;
							next_data = head.value;
						end
						STEP_DRAIN: begin
							// wait until every expected result has been taken
							if (expected_results.size() == 0) begin
								if (drain_left > 0) begin
									drain_left--;
								end else begin
									void'(scan_plan.pop_front());
									drain_left = DRAIN_WAIT;
								end
							end
						end
						STEP_HOLD: begin
							void'(scan_plan.pop_front());
							hold_requests <= hold_requests + 1;
						end
					endcase
				end
			end
		end
		s_tvalid <= sample_busy;
		s_tdata <= next_tdata;
		cfg_valid <= write_busy;
		cfg_index <= next_index;
		cfg_data <= next_data;
	end

	// ------------------------------------------------------------------
	// receiver: random stalls plus long holds on request
	// ------------------------------------------------------------------
	int          holds_served = 0;
	int unsigned hold_left = 0;
	int unsigned stall_left = 0;
	logic        recv_calm = 1'b0;

	always @(negedge clk) begin : receiver
		logic rdy;
		rdy = 1'b0;
		if (arst_n) begin
			if (hold_requests != holds_served) begin
				holds_served++;
				holds_done++;
				hold_left = LONG_HOLD;
			end else if (hold_left > 0) begin
				hold_left--;
			end else if (stall_left > 0) begin
				stall_left--;
			end else begin
				if ($urandom_range(0, 199) == 0)
					recv_calm = !recv_calm;
				stall_left = recv_calm ? 0 : draw_gap();
				if (stall_left == 0)
					rdy = 1'b1;
				else
					stall_left--;
			end
		end
		m_tready <= rdy;
	end

	// ------------------------------------------------------------------
	// plan, reset and end of run
	// ------------------------------------------------------------------
	initial begin : run
		logic [4:0] pattern, s;
		int         seg_len, tick_mod, batch_end;
		// zero windows, zero settle and zero pause: one decision per sample outside the pause
		add_settings(8'd0, 8'd0, 8'd0, 8'd0);
		for (int i = 0; i < 16; i++)
			add_sample(5'h00, 1'(i));
		for (int i = 0; i < 8; i++)
			add_sample(5'h1f, 1'(i >> 1));

		for (int b = 0; b < BATCHES; b++) begin
			case (b)
				0: add_settings(8'd255, 8'd255, 8'd0, 8'd255);
				1: add_settings(8'd0, 8'd0, 8'd255, 8'd0);
				2: add_settings(PRESS_WINDOW_RST, RELEASE_WINDOW_RST, SETTLE_RST, PAUSE_RST);
				default: add_settings(pick_setting(), pick_setting(), pick_setting(),
					pick_setting());
			endcase
			// receiver holds off while samples keep coming
			if (b % 5 == 3)
				scan_plan.push_back('{STEP_HOLD, 5'h1f, 1'b0, REG_PRESS_WINDOW, '0});
			batch_end = planned_samples + BATCH_LEN;
			while (planned_samples < batch_end) begin
				if ($urandom_range(0, 6) == 0) begin
					// noise burst
					seg_len = $urandom_range(1, 6);
					if (seg_len > batch_end - planned_samples)
						seg_len = batch_end - planned_samples;
					for (int i = 0; i < seg_len; i++)
						add_sample(5'($urandom), 1'($urandom));
				end else begin
					// held key pattern with occasional bounce
					pattern = ~(5'($urandom) & 5'($urandom));
					seg_len = $urandom_range(4, 40);
					if (seg_len > batch_end - planned_samples)
						seg_len = batch_end - planned_samples;
					tick_mod = $urandom_range(1, 4);
					for (int i = 0; i < seg_len; i++) begin
						s = pattern;
						if ($urandom_range(0, 19) == 0)
							s = s ^ (5'd1 << $urandom_range(0, 4));
						add_sample(s, $urandom_range(1, tick_mod) == 1);
					end
				end
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (scan_plan.size() != 0 || sample_busy || write_busy
				|| expected_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		@(negedge clk);
		$display("run covered %0d samples, %0d register writes, %0d new-key reports",
			planned_samples, writes_done, keys_reported);
		$display("%0d long result holds with input backpressure", holds_done);
		if (check_errors == 0)
			$display("keypad_matrix_scanner_unit regression: pass");
		else
			$display("keypad_matrix_scanner_unit regression: fail");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#12_000_000;
		$display("keypad_matrix_scanner_unit regression: fail");
		$finish;
	end

endmodule
